FILE: rtl/gnrm_pkg.sv
// ----------------------------------------------------------------------------
// gnrm_pkg
// Shared widths, codes, templates and types of the grid neighbour ring mask.
// ----------------------------------------------------------------------------
`default_nettype none

package gnrm_pkg;

  localparam int CELL_W     = 20;
  localparam int SIDE_CFG_W = 11;
  localparam int MIN_SIDE   = 5;
  localparam int DATA_IN_W  = 24;
  localparam int DATA_OUT_W = 40;

  localparam logic [SIDE_CFG_W-1:0] SIDE_RST = 11'd128;

  // Band codes for the 3x3 and 5x5 classes.
  localparam logic [1:0] BAND3_FIRST = 2'd0;
  localparam logic [1:0] BAND3_MID   = 2'd1;
  localparam logic [1:0] BAND3_LAST  = 2'd2;

  localparam logic [2:0] BAND5_FIRST  = 3'd0;
  localparam logic [2:0] BAND5_SECOND = 3'd1;
  localparam logic [2:0] BAND5_MID    = 3'd2;
  localparam logic [2:0] BAND5_PENULT = 3'd3;
  localparam logic [2:0] BAND5_LAST   = 3'd4;

  typedef logic signed [2:0] ofs_t;

  localparam ofs_t OFS_M2 = -3'sd2;
  localparam ofs_t OFS_M1 = -3'sd1;
  localparam ofs_t OFS_Z  = 3'sd0;
  localparam ofs_t OFS_P1 = 3'sd1;
  localparam ofs_t OFS_P2 = 3'sd2;

  // Neighbour templates, row and column offsets in mask bit order.
  localparam ofs_t INNER_DR [8] = '{OFS_M1, OFS_M1, OFS_M1, OFS_Z, OFS_Z,
                                    OFS_P1, OFS_P1, OFS_P1};
  localparam ofs_t INNER_DC [8] = '{OFS_M1, OFS_Z, OFS_P1, OFS_M1, OFS_P1,
                                    OFS_M1, OFS_Z, OFS_P1};
  localparam ofs_t OUTER_DR [16] = '{OFS_M2, OFS_M2, OFS_M2, OFS_M2, OFS_M2,
                                     OFS_M1, OFS_M1, OFS_Z, OFS_Z, OFS_P1, OFS_P1,
                                     OFS_P2, OFS_P2, OFS_P2, OFS_P2, OFS_P2};
  localparam ofs_t OUTER_DC [16] = '{OFS_M2, OFS_M1, OFS_Z, OFS_P1, OFS_P2,
                                     OFS_M2, OFS_P2, OFS_M2, OFS_P2, OFS_M2, OFS_P2,
                                     OFS_M2, OFS_M1, OFS_Z, OFS_P1, OFS_P2};

  // Edge tests of one coordinate p against side s.
  typedef struct packed {
    logic ge1;  // p >= 1
    logic ge2;  // p >= 2
    logic lt1;  // p + 1 < s
    logic lt2;  // p + 2 < s
  } gnrm_edge_t;

  // Result fields, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] outer_mask;
    logic [7:0]  inner_mask;
    logic [4:0]  outer_class;
    logic [3:0]  inner_class;
  } gnrm_result_t;

endpackage

`default_nettype wire

FILE: rtl/gnrm_div_stage.sv
// ----------------------------------------------------------------------------
// gnrm_div_stage
// One restoring division step: settles quotient bit BIT of index / side.
// ----------------------------------------------------------------------------
`default_nettype none

module gnrm_div_stage import gnrm_pkg::*; #(
  parameter int SW  = 11,
  parameter int QW  = 10,
  parameter int BIT = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SW-1:0]     side_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [CELL_W-1:0] rem_i,
  input  wire logic [QW-1:0]     quo_i,
  input  wire logic              oog_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [CELL_W-1:0]      rem_o,
  output logic [QW-1:0]          quo_o,
  output logic                   oog_o
);

  localparam int AW = CELL_W + SW;

  logic              valid_q;
  logic [CELL_W-1:0] rem_d, rem_q;
  logic [QW-1:0]     quo_d, quo_q;
  logic              oog_q;
  logic [AW-1:0]     rem_ext;
  logic [AW-1:0]     dvs_shift;
  logic              take;

  always_comb begin
    rem_ext   = AW'(rem_i);
    dvs_shift = AW'(side_i) << BIT;
    take      = (rem_ext >= dvs_shift);
    rem_d     = take ? CELL_W'(rem_ext - dvs_shift) : rem_i;
    quo_d     = quo_i;
    quo_d[BIT] = take;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      oog_q <= oog_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign oog_o   = oog_q;

endmodule

`default_nettype wire

FILE: rtl/gnrm_classify.sv
// ----------------------------------------------------------------------------
// gnrm_classify
// Output stage: bands, classes and in-grid masks from row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module gnrm_classify import gnrm_pkg::*; #(
  parameter int SW = 11,
  parameter int QW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [SW-1:0] side_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [QW-1:0] row_i,
  input  wire logic [QW-1:0] col_i,
  input  wire logic          oog_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output gnrm_result_t       result_o,
  output logic               oog_o
);

  logic         valid_q;
  gnrm_result_t res_d, res_q;
  logic         oog_q;
  logic [SW-1:0] side_m1, side_m2;
  gnrm_edge_t   row_e, col_e;
  logic [1:0]   rb3, cb3;
  logic [2:0]   rb5, cb5;

  function automatic gnrm_edge_t edge_tests(logic [QW-1:0] p, logic [SW-1:0] sm1,
                                            logic [SW-1:0] sm2);
    gnrm_edge_t e;
    e.ge1 = (p != '0);
    e.ge2 = (p > QW'(1));
    e.lt1 = (SW'(p) < sm1);
    e.lt2 = (SW'(p) < sm2);
    return e;
  endfunction

  function automatic logic axis_ok(gnrm_edge_t e, ofs_t ofs);
    logic ok;
    case (ofs)
      OFS_M2:  ok = e.ge2;
      OFS_M1:  ok = e.ge1;
      OFS_Z:   ok = 1'b1;
      OFS_P1:  ok = e.lt1;
      OFS_P2:  ok = e.lt2;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [1:0] band3(gnrm_edge_t e);
    logic [1:0] b;
    if (!e.ge1)      b = BAND3_FIRST;
    else if (!e.lt1) b = BAND3_LAST;
    else             b = BAND3_MID;
    return b;
  endfunction

  function automatic logic [2:0] band5(gnrm_edge_t e);
    logic [2:0] b;
    if (!e.ge1)      b = BAND5_FIRST;
    else if (!e.ge2) b = BAND5_SECOND;
    else if (!e.lt2 && e.lt1) b = BAND5_PENULT;
    else if (!e.lt1) b = BAND5_LAST;
    else             b = BAND5_MID;
    return b;
  endfunction

  always_comb begin
    side_m1 = side_i - SW'(1);
    side_m2 = side_i - SW'(2);
    row_e   = edge_tests(row_i, side_m1, side_m2);
    col_e   = edge_tests(col_i, side_m1, side_m2);
    rb3     = band3(row_e);
    cb3     = band3(col_e);
    rb5     = band5(row_e);
    cb5     = band5(col_e);
    res_d   = '0;
    if (!oog_i) begin
      res_d.inner_class = 4'({2'b00, rb3} * 4'd3) + 4'({2'b00, cb3});
      res_d.outer_class = 5'({2'b00, rb5} * 5'd5) + 5'({2'b00, cb5});
      for (int j = 0; j < 8; j++) begin
        res_d.inner_mask[j] = axis_ok(row_e, INNER_DR[j]) & axis_ok(col_e, INNER_DC[j]);
      end
      for (int j = 0; j < 16; j++) begin
        res_d.outer_mask[j] = axis_ok(row_e, OUTER_DR[j]) & axis_ok(col_e, OUTER_DC[j]);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
      oog_q <= oog_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
  assign oog_o    = oog_q;

endmodule

`default_nettype wire

FILE: rtl/grid_neighbour_ring_mask.sv
// Stages: a front register, the divider steps and the classify stage, in that order.
// Throughput: one request per cycle while not stalled; the restoring divider gives one
// quotient bit per pipeline stage, so its stage count sets the latency but not the rate.
// Each stage stalls only when it is full and the stage after it is stalled.
// Reset clears all valid bits and loads the grid side register with 128.
// ----------------------------------------------------------------------------
// grid_neighbour_ring_mask
// Splits a linear cell index into row and column and classifies its position
// against the grid edges, with masks of the in-grid neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbour_ring_mask import gnrm_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [SIDE_CFG_W-1:0] cfg_wdata_i,   // grid_side
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [DATA_IN_W-1:0]  s_axis_tdata,  // [19:0] cell_index
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [3:0] inner_class, [8:4] outer_class, [16:9] inner_mask, [32:17] outer_mask
  output logic [DATA_OUT_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tuser   // [0] out_of_grid
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int QW   = $clog2(MAX_SIDE);
  localparam int SQW  = 2 * SW;
  localparam int CMPW = (SQW > CELL_W) ? SQW : CELL_W;
  localparam int RESW = $bits(gnrm_result_t);

  logic [SIDE_CFG_W-1:0] side_cfg_q;
  logic [SW-1:0]         side_eff;

  // Stage position 0 is the front register, 1..QW are the divider steps.
  logic              v    [QW+1];
  logic              rdy  [1:QW+1];
  logic [CELL_W-1:0] rem  [QW+1];
  logic [QW-1:0]     quo  [QW+1];
  logic              oog  [QW+1];

  logic              front_v_q;
  logic [CELL_W-1:0] front_idx_q;
  logic [SQW-1:0]    front_sq_q;
  logic              front_oog;

  gnrm_result_t      result;
  logic              res_oog;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q <= SIDE_RST;
    end else if (cfg_we_i) begin
      side_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (side_cfg_q < SIDE_CFG_W'(MIN_SIDE)) begin
      side_eff = SW'(MIN_SIDE);
    end else if (32'(side_cfg_q) > 32'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(side_cfg_q);
    end
  end

  // Front stage: latch the index and the squared side.
  assign s_axis_tready = !front_v_q || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      front_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      front_idx_q <= s_axis_tdata[CELL_W-1:0];
      front_sq_q  <= SQW'(side_eff) * SQW'(side_eff);
    end
  end

  assign front_oog = (CMPW'(front_idx_q) >= CMPW'(front_sq_q));

  assign v[0]   = front_v_q;
  assign rem[0] = front_idx_q;
  assign quo[0] = '0;
  assign oog[0] = front_oog;

  for (genvar i = 1; i <= QW; i++) begin : g_div
    gnrm_div_stage #(
      .SW  (SW),
      .QW  (QW),
      .BIT (QW - i)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .side_i  (side_eff),
      .valid_i (v[i-1]),
      .ready_o (rdy[i]),
      .rem_i   (rem[i-1]),
      .quo_i   (quo[i-1]),
      .oog_i   (oog[i-1]),
      .valid_o (v[i]),
      .ready_i (rdy[i+1]),
      .rem_o   (rem[i]),
      .quo_o   (quo[i]),
      .oog_o   (oog[i])
    );
  end

  gnrm_classify #(
    .SW (SW),
    .QW (QW)
  ) u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .side_i   (side_eff),
    .valid_i  (v[QW]),
    .ready_o  (rdy[QW+1]),
    .row_i    (quo[QW]),
    .col_i    (rem[QW][QW-1:0]),
    .oog_i    (oog[QW]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result),
    .oog_o    (res_oog)
  );

  assign m_axis_tdata = {(DATA_OUT_W - RESW)'(0), result};
  assign m_axis_tuser = res_oog;

  // An index beyond the grid carries no class and no mask bits.
  a_oog_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_oog |-> result == '0)
    else $error("out-of-grid result carries nonzero fields");

  // Classes stay within their band products.
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_oog |-> result.inner_class < 4'd9 && result.outer_class < 5'd25)
    else $error("class out of range");

  // The upper neighbour exists exactly when the row is not the first.
  a_up_vs_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_oog |-> result.inner_mask[1] == (result.inner_class >= 4'd3))
    else $error("upper neighbour bit disagrees with inner class");

  // A middle cell of the 5x5 bands sees the whole distance-2 ring.
  a_mid_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_oog && result.outer_class == 5'd12 |->
      result.outer_mask == 16'hFFFF && result.inner_mask == 8'hFF)
    else $error("middle cell lacks a full ring");

endmodule

`default_nettype wire
